// ----- src/counter_priority_task_scheduler_defines.svh -----
// Assertion macros for the counter priority task scheduler.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// check on every clock edge outside reset
`define CPTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every clock edge, reset included
`define CPTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/cpts_pkg.sv -----
// Shared types, constants and helpers of the task scheduler.
// No dependencies.
package cpts_pkg;

  localparam int TaskSlots = 64;
  localparam int IdxW      = $clog2(TaskSlots);
  localparam int CntW      = $clog2(TaskSlots + 1);

  typedef enum logic [2:0] {
    FnTick  = 3'd0,
    FnYield = 3'd1,
    FnPdis  = 3'd2,
    FnPen   = 3'd3,
    FnWrite = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScan,
    StRech,
    StFRead,
    StDone
  } state_e;

  typedef struct packed {
    logic               present;
    logic               running;
    logic [7:0]         prio;
    logic signed [15:0] counter;
    logic [7:0]         depth;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
  } tbl_req_t;

  function automatic entry_t reset_entry(logic [IdxW-1:0] idx);
    entry_t e;
    e = '0;
    if (idx == '0) begin
      e.present = 1'b1;
      e.running = 1'b1;
      e.prio    = 8'd1;
    end
    return e;
  endfunction

endpackage

// ----- src/cpts_if.sv -----
// Valid/ready channel interfaces for the task scheduler: event words in,
// result words out. No dependencies.
interface cpts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [5:0] slot_index;
  logic       slot_present;
  logic       slot_running;
  logic [7:0] slot_priority;
  logic [8:0] slot_counter;

  modport source (output valid, func, slot_index, slot_present, slot_running,
                  slot_priority, slot_counter, input ready);
  modport sink (input valid, func, slot_index, slot_present, slot_running,
                slot_priority, slot_counter, output ready);
endinterface

interface cpts_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         current_task;
  logic               switched;
  logic signed [15:0] current_counter;

  modport source (output valid, current_task, switched, current_counter, input ready);
  modport sink (input valid, current_task, switched, current_counter, output ready);
endinterface

// ----- src/cpts_ram.sv -----
// Generic synchronous RAM, one write port and one read port, registered read.
// No dependencies.
module cpts_ram #(
  parameter int Depth = 64,
  parameter int Width = 34
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/cpts_table.sv -----
// Task slot table: RAM of slot entries plus written flags that give unwritten
// slots their reset contents. Depends on cpts_pkg and cpts_ram.
module cpts_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpts_pkg::tbl_req_t req_i,
  output cpts_pkg::entry_t  rd_entry_o
);
  import cpts_pkg::*;

  logic [TaskSlots-1:0] valid_q;
  logic                 rd_valid_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic [EntryW-1:0]    rdata;

  cpts_ram #(
    .Depth (TaskSlots),
    .Width (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
        rd_idx_q   <= req_i.raddr;
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? entry_t'(rdata) : reset_entry(rd_idx_q);

endmodule

// ----- src/counter_priority_task_scheduler.sv -----
// Counter priority task scheduler: one event word in, one result word out.
// Takes the event channel and result channel of cpts_if; depends on cpts_pkg,
// cpts_table and the assertion macros.
//
// Event words carry func (tick, yield, preempt disable, preempt enable, slot
// write) and the slot fields used by a slot write. Each accepted event gives
// exactly one result word: the current task, whether it changed, and its
// time counter after the event.
// One event is worked at a time; in_i.ready is high while the sequencer waits.
// All slot state lives in one RAM and its written flags, read-modify-written one slot per cycle.
// Events without a reschedule write their slot back, re-read the current task and
// give their result; the next event is taken once the result is registered. A
// reschedule sweeps the table once, and when the highest runnable counter is zero
// it sweeps again to recharge and once more to pick.
// Reset leaves slot 0 present and runnable as the current task, with
// counter 0, priority 1 and no preemption depth; no clearing pass is needed.
// A finished result sits in the output register until taken; the next event
// is accepted meanwhile, and its result waits for the register to empty.
`include "counter_priority_task_scheduler_defines.svh"

module counter_priority_task_scheduler (
  input logic        clk_i,
  input logic        rst_ni,
  cpts_in_if.sink    in_i,
  cpts_out_if.source out_o
);
  import cpts_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] before_q, before_d;
  func_e           func_q, func_d;
  logic [5:0]      slot_q, slot_d;
  logic            spres_q, spres_d;
  logic            srun_q, srun_d;
  logic [7:0]      sprio_q, sprio_d;
  logic [8:0]      scnt_q, scnt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic signed [15:0] best_q, best_d;
  logic [IdxW-1:0] pick_q, pick_d;
  logic            rech_q, rech_d;
  logic            out_valid_q, out_valid_d;
  logic [5:0]      out_task_q, out_task_d;
  logic            out_sw_q, out_sw_d;
  logic signed [15:0] out_cnt_q, out_cnt_d;

  tbl_req_t           req;
  entry_t             e;
  entry_t             we_entry;
  logic signed [15:0] cm;
  logic               in_acc;
  logic               slot_ok;
  logic               sweep_more;

  cpts_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rd_entry_o (e)
  );

  assign in_i.ready            = (state_q == StIdle);
  assign in_acc                = in_i.valid && in_i.ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.current_task    = out_task_q;
  assign out_o.switched        = out_sw_q;
  assign out_o.current_counter = out_cnt_q;

  assign slot_ok    = (32'(slot_q) < TaskSlots);
  assign sweep_more = (cnt_q != CntW'(TaskSlots));
  assign cm         = (e.counter == 16'sh8000) ? e.counter : e.counter - 16'sd1;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    before_d    = before_q;
    func_d      = func_q;
    slot_d      = slot_q;
    spres_d     = spres_q;
    srun_d      = srun_q;
    sprio_d     = sprio_q;
    scnt_d      = scnt_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    best_d      = best_q;
    pick_d      = pick_q;
    rech_d      = rech_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_task_d  = out_task_q;
    out_sw_d    = out_sw_q;
    out_cnt_d   = out_cnt_q;
    req         = '0;
    we_entry    = e;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          func_d   = func_e'(in_i.func);
          slot_d   = in_i.slot_index;
          spres_d  = in_i.slot_present;
          srun_d   = in_i.slot_running;
          sprio_d  = in_i.slot_priority;
          scnt_d   = in_i.slot_counter;
          before_d = cur_q;
          req.re   = 1'b1;
          req.raddr = (func_e'(in_i.func) == FnWrite) ? IdxW'(in_i.slot_index) : cur_q;
          state_d  = StExec;
        end
      end
      StExec: begin
        req.waddr = cur_q;
        state_d   = StFRead;
        cnt_d     = '0;
        pend_d    = 1'b0;
        best_d    = -16'sd1;
        pick_d    = '0;
        rech_d    = 1'b0;
        unique case (func_q)
          FnTick: begin
            req.we = 1'b1;
            if (cm > 16'sd0 || e.depth != 8'd0) begin
              we_entry.counter = cm;
            end else begin
              we_entry.counter = '0;
              state_d = StScan;
            end
          end
          FnYield: begin
            req.we = 1'b1;
            we_entry.counter = '0;
            state_d = StScan;
          end
          FnPdis: begin
            req.we = 1'b1;
            if (e.depth != 8'hff) begin
              we_entry.depth = e.depth + 8'd1;
            end
          end
          FnPen: begin
            req.we = 1'b1;
            if (e.depth != 8'd0) begin
              we_entry.depth = e.depth - 8'd1;
            end
          end
          FnWrite: begin
            req.we           = slot_ok;
            req.waddr        = IdxW'(slot_q);
            we_entry.present = spres_q;
            we_entry.running = srun_q;
            we_entry.prio    = sprio_q;
            we_entry.counter = 16'(scnt_q);
          end
          default: begin
          end
        endcase
      end
      StScan: begin
        req.re    = sweep_more;
        req.raddr = cnt_q[IdxW-1:0];
        pend_d    = sweep_more;
        pidx_d    = cnt_q[IdxW-1:0];
        if (sweep_more) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (pend_q && e.present && e.running && e.counter > best_q) begin
          best_d = e.counter;
          pick_d = pidx_q;
        end
        if (!sweep_more && !pend_q) begin
          cnt_d = '0;
          if (best_q == 16'sd0 && !rech_q) begin
            rech_d  = 1'b1;
            state_d = StRech;
          end else begin
            cur_d   = pick_q;
            state_d = StFRead;
          end
        end
      end
      StRech: begin
        req.re    = sweep_more;
        req.raddr = cnt_q[IdxW-1:0];
        pend_d    = sweep_more;
        pidx_d    = cnt_q[IdxW-1:0];
        if (sweep_more) begin
          cnt_d = cnt_q + CntW'(1);
        end
        req.we    = pend_q && e.present;
        req.waddr = pidx_q;
        we_entry.counter = (e.counter >>> 1) + $signed(16'(e.prio));
        if (!sweep_more && !pend_q) begin
          cnt_d   = '0;
          best_d  = -16'sd1;
          pick_d  = '0;
          state_d = StScan;
        end
      end
      StFRead: begin
        req.re    = 1'b1;
        req.raddr = cur_q;
        state_d   = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_task_d  = 6'(cur_q);
          out_sw_d    = (cur_q != before_q);
          out_cnt_d   = e.counter;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    req.wdata = we_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      rech_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      rech_q      <= rech_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    before_q   <= before_d;
    func_q     <= func_d;
    slot_q     <= slot_d;
    spres_q    <= spres_d;
    srun_q     <= srun_d;
    sprio_q    <= sprio_d;
    scnt_q     <= scnt_d;
    pidx_q     <= pidx_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    out_task_q <= out_task_d;
    out_sw_q   <= out_sw_d;
    out_cnt_q  <= out_cnt_d;
  end

  `CPTS_ASSERT_ALWAYS(a_no_rw_overlap, !(req.we && req.re) || req.waddr != req.raddr, "table read and write hit the same slot in one cycle")
  `CPTS_ASSERT(a_cur_from_scan, !$stable(cur_q) |-> $past(state_q) == StScan, "current task changed outside a reschedule")
  `CPTS_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q) == StDone, "result word raised outside the result stage")

endmodule
